/* hdl/hir_pkg.sv */
package hir_pkg;

   // Table geometry.
   localparam int CAPACITY  = 256;
   localparam int KEY_WIDTH = 64;
   localparam int ID_W      = 32;
   localparam int IDX_W     = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int ENTRY_W   = KEY_WIDTH + ID_W;

   // Request operation codes.
   localparam logic [1:0] OP_REGISTER = 2'd0;
   localparam logic [1:0] OP_LOOKUP   = 2'd1;
   localparam logic [1:0] OP_REMOVE   = 2'd2;

   // Response status codes.
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_MISSING = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

endpackage

/* hdl/handle_id_registry_core.sv */
// Handle registry: a compact table of up to CAPACITY handles, each paired with a unique
// 32-bit identifier from a counter that only rises and wraps modulo 2^32. A register beat
// appends the handle with the next identifier (status full when the table holds CAPACITY
// entries). A lookup beat returns the identifier of the lowest-indexed live copy of
// the handle, and a remove beat returns that identifier, moves the last live entry into
// its slot and shrinks the table; an unknown handle or the unused op code answers
// not-found with ident 0. One request is worked on at a time. A register passes through
// the exec and finish states before its response is registered; a lookup or remove also
// scans the live entries in order from index 0, and a remove then reads the last entry
// and writes it into the hole. The scan is bound by the single read port of the entry
// memory, which it walks one entry per cycle. The memory contents need no clearing after
// reset, since only live entries are ever read.
module handle_id_registry_core
   import hir_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_op,
   input  logic [63:0]          req_handle,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ID_W-1:0]      rsp_ident,
   output logic [1:0]           rsp_status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_RD_LAST,
      ST_WR_LAST,
      ST_FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic [1:0]           op_ff, op_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [ID_W-1:0]      next_id_ff, next_id_in;
   logic [CNT_W-1:0]     issue_ff, issue_in;
   logic                 pend_ff, pend_in;
   logic [IDX_W-1:0]     pend_idx_ff, pend_idx_in;
   logic [IDX_W-1:0]     pos_ff, pos_in;
   logic [ID_W-1:0]      res_ident_ff, res_ident_in;
   logic [1:0]           res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]      rsp_ident_ff, rsp_ident_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;

   // Entry memory port signals. Each entry holds {key, ident}.
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [ENTRY_W-1:0]   wr_data;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic [ENTRY_W-1:0]   rd_data;
   logic [KEY_WIDTH-1:0] rd_key;
   logic [ID_W-1:0]      rd_ident;
   logic [CNT_W-1:0]     last_idx;

   assign rd_key   = rd_data[ENTRY_W-1:ID_W];
   assign rd_ident = rd_data[ID_W-1:0];
   assign last_idx = count_ff - CNT_W'(1);

   hir_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // A new request is only taken while the sequencer is idle. A finished response may
   // still be waiting in the output register at that time.
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      count_in      = count_ff;
      next_id_in    = next_id_ff;
      issue_in      = issue_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      pos_in        = pos_ff;
      res_ident_in  = res_ident_ff;
      res_status_in = res_status_ff;
      rsp_ident_in  = rsp_ident_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      wr_en   = 1'b0;
      wr_addr = count_ff[IDX_W-1:0];
      wr_data = {key_ff, next_id_ff};
      rd_en   = 1'b0;
      rd_addr = issue_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               key_in   = req_handle[KEY_WIDTH-1:0];
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            res_ident_in  = '0;
            res_status_in = STATUS_MISSING;
            issue_in      = '0;
            pend_in       = 1'b0;
            unique case (op_ff) inside
               OP_REGISTER: begin
                  if (count_ff >= CNT_W'(CAPACITY)) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     // Append at the end of the live entries.
                     wr_en         = 1'b1;
                     res_ident_in  = next_id_ff;
                     res_status_in = STATUS_OK;
                     next_id_in    = next_id_ff + ID_W'(1);
                     count_in      = count_ff + CNT_W'(1);
                  end
                  state_in = ST_FINISH;
               end
               OP_LOOKUP, OP_REMOVE: begin
                  state_in = ST_SCAN;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end

         ST_SCAN: begin
            // Issue the next read while the previous entry's data is compared.
            if (issue_ff < count_ff) begin
               rd_en       = 1'b1;
               issue_in    = issue_ff + CNT_W'(1);
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[IDX_W-1:0];
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && (rd_key == key_ff)) begin
               res_ident_in = rd_ident;
               pend_in      = 1'b0;
               if (op_ff == OP_REMOVE) begin
                  pos_in   = pend_idx_ff;
                  state_in = ST_RD_LAST;
               end else begin
                  res_status_in = STATUS_OK;
                  state_in      = ST_FINISH;
               end
            end else if (!pend_ff && (issue_ff >= count_ff)) begin
               // Every live entry has been compared without a match.
               state_in = ST_FINISH;
            end
         end

         ST_RD_LAST: begin
            rd_en    = 1'b1;
            rd_addr  = last_idx[IDX_W-1:0];
            state_in = ST_WR_LAST;
         end

         ST_WR_LAST: begin
            // Move the last live entry into the hole; harmless when they coincide.
            wr_en         = 1'b1;
            wr_addr       = pos_ff;
            wr_data       = rd_data;
            count_in      = last_idx;
            res_status_in = STATUS_OK;
            state_in      = ST_FINISH;
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_ident_in  = res_ident_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         next_id_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         next_id_ff   <= next_id_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      issue_ff      <= issue_in;
      pend_idx_ff   <= pend_idx_in;
      pos_ff        <= pos_in;
      res_ident_ff  <= res_ident_in;
      res_status_ff <= res_status_in;
      rsp_ident_ff  <= rsp_ident_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_ident  = rsp_ident_ff;
   assign rsp_status = rsp_status_ff;

endmodule

/* hdl/hir_ram.sv */
module hir_ram #(
   parameter int WIDTH  = 96,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one read port; read data is registered.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
